// ----- rtl/core/bedc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, register indexes and saturating arithmetic helpers for the
// boost energy duty controller. No dependencies.
package bedc_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_INDUCTANCE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITANCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FILT_WEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd6;

	localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
	localparam logic [15:0] DUTY_MAX     = 16'd64225;
	localparam logic [31:0] PERIOD_RESET = 32'd10995116;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	// Apply a sign to an unsigned magnitude, saturating to the signed range.
	function automatic logic signed [63:0] sat_signed(input logic [63:0] m, input logic neg);
		logic signed [63:0] r;
		if (neg) begin
			r = m[63] ? S64_MIN : $signed(~m + 64'd1);
		end else begin
			r = m[63] ? S64_MAX : $signed(m);
		end
		return r;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if ((a[63] == b[63]) && (s[63] != a[63])) begin
			s = a[63] ? S64_MIN : S64_MAX;
		end
		return s;
	endfunction

	// Negation where the most negative value maps to the most positive one.
	function automatic logic signed [63:0] neg_sat(input logic signed [63:0] t);
		return (t == S64_MIN) ? S64_MAX : -t;
	endfunction

endpackage

// ----- rtl/core/bedc_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the boost energy duty controller: the
// configuration write channel, the sample channel and the result channel. Uses bedc_pkg.
interface bedc_cfg_if;
	import bedc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface bedc_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [31:0] inductor_current;
	logic signed [31:0] output_current;
	logic signed [31:0] input_voltage;
	logic signed [31:0] output_voltage;
	logic signed [31:0] voltage_setpoint;
	modport source (output valid, output mode, output inductor_current, output output_current,
		output input_voltage, output output_voltage, output voltage_setpoint, input ready);
	modport sink (input valid, input mode, input inductor_current, input output_current,
		input input_voltage, input output_voltage, input voltage_setpoint, output ready);
endinterface

interface bedc_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        duty;
	logic signed [31:0] setpoint_echo;
	logic [47:0]        stored_energy;
	logic [47:0]        reference_energy;
	logic signed [31:0] filtered_current_out;
	logic               fault;
	modport source (output valid, output duty, output setpoint_echo, output stored_energy,
		output reference_energy, output filtered_current_out, output fault, input ready);
	modport sink (input valid, input duty, input setpoint_echo, input stored_energy,
		input reference_energy, input filtered_current_out, input fault, output ready);
endinterface

// ----- rtl/core/boost_energy_duty_controller_core.sv -----
`timescale 1ns / 1ps
// Boost converter duty controller, energy based with integral action.
// A full control step ends with the duty division, skipped when the numerator is out of
// range; each division has 64 steps. A voltage fault ends the step after the stored
// energy and a clear request zeroes the integral and goes straight to the result. One
// sample is handled at a time, the next taken in the cycle after the result transfer.
// Asynchronous active-low reset clears the sequencer, the integral and the current
// average and sets the configuration registers to their reset values.
module boost_energy_duty_controller_core (
	input logic        clk,
	input logic        arst_n,
	bedc_cfg_if.sink   cfg,
	bedc_in_if.sink    sample,
	bedc_out_if.source result
);
	import bedc_pkg::*;

	// Sequencer states. Each arithmetic state waits for the shared
	// multiplier or the divider to finish before moving on.
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_F1   = 5'd1;
	localparam logic [4:0] ST_F2   = 5'd2;
	localparam logic [4:0] ST_EN1  = 5'd3;
	localparam logic [4:0] ST_EN2  = 5'd4;
	localparam logic [4:0] ST_EN3  = 5'd5;
	localparam logic [4:0] ST_EN4  = 5'd6;
	localparam logic [4:0] ST_D1   = 5'd7;
	localparam logic [4:0] ST_D2   = 5'd8;
	localparam logic [4:0] ST_V    = 5'd9;
	localparam logic [4:0] ST_I1   = 5'd10;
	localparam logic [4:0] ST_P1   = 5'd11;
	localparam logic [4:0] ST_P2   = 5'd12;
	localparam logic [4:0] ST_P3   = 5'd13;
	localparam logic [4:0] ST_P4   = 5'd14;
	localparam logic [4:0] ST_Q    = 5'd15;
	localparam logic [4:0] ST_N    = 5'd16;
	localparam logic [4:0] ST_U    = 5'd17;
	localparam logic [4:0] ST_OUT  = 5'd18;

	// Multiplier unit phases.
	localparam logic [2:0] U_IDLE = 3'd0;
	localparam logic [2:0] U_LO   = 3'd1;
	localparam logic [2:0] U_HI   = 3'd2;
	localparam logic [2:0] U_FIN  = 3'd3;
	localparam logic [2:0] U_DONE = 3'd4;

	// Divider phases.
	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_RUN  = 2'd1;
	localparam logic [1:0] D_DONE = 2'd2;
	localparam int unsigned DIV_STEPS = 64;

	// Configuration registers.
	logic [31:0]        ind_q, cap_q, per_q;
	logic signed [31:0] ki_q, k1_q, k2_q;
	logic [16:0]        fw_q;

	// Controller state and working registers.
	logic [4:0]         st_q;
	logic               eph_q;
	logic signed [63:0] ei_q;
	logic signed [31:0] filt_q;
	logic signed [31:0] il_q, io_q, vi_q, vo_q, vs_q;
	logic               fault_q;
	logic signed [63:0] tmp_q, edot_q, rho_q;
	logic [63:0]        sq_q, eacc_q;
	logic [47:0]        e_q, eref_q;
	logic signed [31:0] ir_q;
	logic [15:0]        duty_q;

	// Shared multiply unit: a 64 by 32 bit unsigned product is built from two
	// 32 by 32 partial products, then shifted right, saturated and signed.
	logic [2:0]         uph_q;
	logic [63:0]        ma_q;
	logic [31:0]        mb_q;
	logic [5:0]         msh_q;
	logic               mneg_q;
	logic [95:0]        acc_q;
	logic signed [63:0] mres_q;
	logic [31:0]        mul_lhs;
	logic [63:0]        mul_prod;
	logic [95:0]        acc_shr;
	logic [63:0]        acc_mag;
	logic               ms_go, ms_done;
	logic [63:0]        op_a;
	logic [31:0]        op_b;
	logic [5:0]         op_sh;
	logic               op_neg;

	// Restoring divider, one quotient bit per cycle.
	logic [1:0]         dph_q;
	logic [63:0]        dq_q;
	logic [31:0]        drem_q, dvs_q;
	logic [5:0]         dcnt_q;
	logic [32:0]        d_trial;
	logic               d_ge;
	logic               div_go, div_done;
	logic [63:0]        dv_a;
	logic [31:0]        dv_b;

	// Combinational helpers of the sequencer.
	logic [16:0]        w_eff;
	logic signed [31:0] cur_sel, volt_sel;
	logic signed [63:0] ed, vo64, vi64, diff_v, f_sum, q_signed, num_val;
	logic [63:0]        e_tot;
	logic [47:0]        e_sat;
	logic signed [31:0] ir_sat;

	// Configuration writes are always taken; an index beyond the list is ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ind_q <= '0;
			cap_q <= '0;
			ki_q  <= '0;
			k1_q  <= '0;
			k2_q  <= '0;
			fw_q  <= WEIGHT_ONE;
			per_q <= PERIOD_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_INDUCTANCE:  ind_q <= cfg.data;
				REG_CAPACITANCE: cap_q <= cfg.data;
				REG_INT_GAIN:    ki_q  <= $signed(cfg.data);
				REG_ENERGY_GAIN: k1_q  <= $signed(cfg.data);
				REG_RATE_GAIN:   k2_q  <= $signed(cfg.data);
				REG_FILT_WEIGHT: fw_q  <= cfg.data[16:0];
				REG_PERIOD:      per_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// A filter weight above one counts as exactly one.
	assign w_eff    = (fw_q > WEIGHT_ONE) ? WEIGHT_ONE : fw_q;
	// The energy states serve both the measured pair and the reference pair.
	assign cur_sel  = eph_q ? ir_q : il_q;
	assign volt_sel = eph_q ? vs_q : vo_q;
	assign ed       = $signed({16'h0, eref_q}) - $signed({16'h0, e_q});
	assign vo64     = 64'(vo_q);
	assign vi64     = 64'(vi_q);
	assign diff_v   = vo64 - vi64;
	assign f_sum    = tmp_q + mres_q;
	assign e_tot    = eacc_q + $unsigned(mres_q);
	assign e_sat    = (|e_tot[63:48]) ? '1 : e_tot[47:0];
	assign q_signed = tmp_q[63] ? -$signed(dq_q) : $signed(dq_q);
	assign num_val  = sat_add(q_signed, diff_v);

	// The reference current is a quotient truncated toward zero and clipped
	// to the 32-bit signed range.
	always_comb begin
		if (tmp_q[63]) begin
			ir_sat = (dq_q > 64'h8000_0000) ? 32'sh8000_0000 : $signed(~dq_q[31:0] + 32'd1);
		end else begin
			ir_sat = (dq_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dq_q[31:0]);
		end
	end

	// Operand selection for the multiply unit.
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sh  = '0;
		op_neg = 1'b0;
		ms_go  = 1'b0;
		case (st_q)
			ST_F1: begin
				op_a   = {32'h0, mag32(io_q)};
				op_b   = {15'h0, w_eff};
				op_neg = io_q[31];
				ms_go  = 1'b1;
			end
			ST_F2: begin
				op_a   = {32'h0, mag32(filt_q)};
				op_b   = {15'h0, WEIGHT_ONE - w_eff};
				op_neg = filt_q[31];
				ms_go  = 1'b1;
			end
			ST_EN1: begin
				op_a  = {32'h0, mag32(cur_sel)};
				op_b  = mag32(cur_sel);
				ms_go = 1'b1;
			end
			ST_EN2: begin
				op_a  = sq_q;
				op_b  = ind_q;
				op_sh = 6'd49;
				ms_go = 1'b1;
			end
			ST_EN3: begin
				op_a  = {32'h0, mag32(volt_sel)};
				op_b  = mag32(volt_sel);
				ms_go = 1'b1;
			end
			ST_EN4: begin
				op_a  = sq_q;
				op_b  = cap_q;
				op_sh = 6'd49;
				ms_go = 1'b1;
			end
			ST_D1: begin
				op_a   = {32'h0, mag32(il_q)};
				op_b   = mag32(vi_q);
				op_neg = il_q[31] ^ vi_q[31];
				ms_go  = 1'b1;
			end
			ST_D2: begin
				op_a   = {32'h0, mag32(filt_q)};
				op_b   = mag32(vo_q);
				op_neg = filt_q[31] ^ vo_q[31];
				ms_go  = 1'b1;
			end
			ST_I1: begin
				op_a   = mag64(ed);
				op_b   = per_q;
				op_sh  = 6'd32;
				op_neg = ed[63];
				ms_go  = 1'b1;
			end
			ST_P1: begin
				op_a   = mag64(ei_q);
				op_b   = mag32(ki_q);
				op_sh  = 6'd24;
				op_neg = ei_q[63] ^ ki_q[31];
				ms_go  = 1'b1;
			end
			ST_P2: begin
				op_a   = {16'h0, e_q};
				op_b   = mag32(k1_q);
				op_sh  = 6'd16;
				op_neg = k1_q[31];
				ms_go  = 1'b1;
			end
			ST_P3: begin
				op_a   = mag64(edot_q);
				op_b   = mag32(k2_q);
				op_sh  = 6'd24;
				op_neg = edot_q[63] ^ k2_q[31];
				ms_go  = 1'b1;
			end
			ST_P4: begin
				op_a   = mag64(rho_q);
				op_b   = ind_q;
				op_sh  = 6'd32;
				op_neg = rho_q[63];
				ms_go  = 1'b1;
			end
			default: ;
		endcase
	end

	// Operand selection for the divider. Both voltages are known positive here.
	always_comb begin
		dv_a   = '0;
		dv_b   = '0;
		div_go = 1'b0;
		case (st_q)
			ST_V, ST_Q: begin
				dv_a   = mag64(tmp_q);
				dv_b   = vi_q;
				div_go = 1'b1;
			end
			ST_U: begin
				dv_a   = {tmp_q[47:0], 16'h0};
				dv_b   = vo_q;
				div_go = 1'b1;
			end
			default: ;
		endcase
	end

	// Multiply unit datapath.
	assign mul_lhs  = (uph_q == U_LO) ? ma_q[31:0] : ma_q[63:32];
	assign mul_prod = 64'(mul_lhs) * 64'(mb_q);
	assign acc_shr  = acc_q >> msh_q;
	assign acc_mag  = (|acc_shr[95:64]) ? '1 : acc_shr[63:0];
	assign ms_done  = (uph_q == U_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uph_q <= U_IDLE;
		end else begin
			case (uph_q)
				U_IDLE:  if (ms_go) uph_q <= U_LO;
				U_LO:    uph_q <= U_HI;
				U_HI:    uph_q <= U_FIN;
				U_FIN:   uph_q <= U_DONE;
				U_DONE:  uph_q <= U_IDLE;
				default: uph_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (uph_q)
			U_IDLE: begin
				ma_q   <= op_a;
				mb_q   <= op_b;
				msh_q  <= op_sh;
				mneg_q <= op_neg;
			end
			U_LO:    acc_q  <= {32'h0, mul_prod};
			U_HI:    acc_q  <= acc_q + {mul_prod, 32'h0};
			U_FIN:   mres_q <= sat_signed(acc_mag, mneg_q);
			default: ;
		endcase
	end

	// Divider datapath: the dividend shifts out of dq_q as quotient bits shift in.
	assign d_trial  = {drem_q, dq_q[63]};
	assign d_ge     = (d_trial >= {1'b0, dvs_q});
	assign div_done = (dph_q == D_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dph_q  <= D_IDLE;
			dcnt_q <= '0;
		end else begin
			case (dph_q)
				D_IDLE: begin
					dcnt_q <= '0;
					if (div_go) dph_q <= D_RUN;
				end
				D_RUN: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'(DIV_STEPS - 1)) dph_q <= D_DONE;
				end
				D_DONE:  dph_q <= D_IDLE;
				default: dph_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (dph_q)
			D_IDLE: begin
				dq_q   <= dv_a;
				drem_q <= '0;
				dvs_q  <= dv_b;
			end
			D_RUN: begin
				dq_q   <= {dq_q[62:0], d_ge};
				drem_q <= d_ge ? 32'(d_trial - {1'b0, dvs_q}) : d_trial[31:0];
			end
			default: ;
		endcase
	end

	// Sequencer and the two state variables that reset clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			eph_q  <= 1'b0;
			ei_q   <= '0;
			filt_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					eph_q <= 1'b0;
					if (sample.valid) begin
						if (sample.mode) begin
							ei_q <= '0;
							st_q <= ST_OUT;
						end else begin
							st_q <= ST_F1;
						end
					end
				end
				ST_F1: if (ms_done) st_q <= ST_F2;
				ST_F2: begin
					if (ms_done) begin
						filt_q <= f_sum[47:16];
						st_q   <= ST_EN1;
					end
				end
				ST_EN1: if (ms_done) st_q <= ST_EN2;
				ST_EN2: if (ms_done) st_q <= ST_EN3;
				ST_EN3: if (ms_done) st_q <= ST_EN4;
				ST_EN4: begin
					if (ms_done) begin
						if (eph_q) st_q <= ST_I1;
						else if (fault_q) st_q <= ST_OUT;
						else st_q <= ST_D1;
					end
				end
				ST_D1: if (ms_done) st_q <= ST_D2;
				ST_D2: if (ms_done) st_q <= ST_V;
				ST_V: begin
					if (div_done) begin
						eph_q <= 1'b1;
						st_q  <= ST_EN1;
					end
				end
				ST_I1: begin
					if (ms_done) begin
						ei_q <= sat_add(ei_q, mres_q);
						st_q <= ST_P1;
					end
				end
				ST_P1: if (ms_done) st_q <= ST_P2;
				ST_P2: if (ms_done) st_q <= ST_P3;
				ST_P3: if (ms_done) st_q <= ST_P4;
				ST_P4: if (ms_done) st_q <= ST_Q;
				ST_Q:  if (div_done) st_q <= ST_N;
				ST_N: begin
					if ((tmp_q <= 64'sd0) || (tmp_q >= vo64)) st_q <= ST_OUT;
					else st_q <= ST_U;
				end
				ST_U:   if (div_done) st_q <= ST_OUT;
				ST_OUT: if (result.ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers. The energy and duty results stay zero when a step does not reach them.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (sample.valid) begin
					il_q    <= sample.inductor_current;
					io_q    <= sample.output_current;
					vi_q    <= sample.input_voltage;
					vo_q    <= sample.output_voltage;
					vs_q    <= sample.voltage_setpoint;
					fault_q <= !sample.mode && ((sample.input_voltage <= 32'sd0) ||
						(sample.output_voltage <= 32'sd0));
					e_q     <= '0;
					eref_q  <= '0;
					duty_q  <= '0;
				end
			end
			ST_F1:  if (ms_done) tmp_q <= mres_q;
			ST_EN1: if (ms_done) sq_q <= $unsigned(mres_q);
			ST_EN2: if (ms_done) eacc_q <= $unsigned(mres_q);
			ST_EN3: if (ms_done) sq_q <= $unsigned(mres_q);
			ST_EN4: begin
				if (ms_done) begin
					if (eph_q) eref_q <= e_sat;
					else e_q <= e_sat;
				end
			end
			ST_D1: if (ms_done) tmp_q <= mres_q;
			ST_D2: begin
				if (ms_done) begin
					edot_q <= tmp_q - mres_q;
					tmp_q  <= mres_q;
				end
			end
			ST_V:  if (div_done) ir_q <= ir_sat;
			ST_P1: if (ms_done) rho_q <= mres_q;
			ST_P2: if (ms_done) rho_q <= sat_add(rho_q, neg_sat(mres_q));
			ST_P3: if (ms_done) rho_q <= sat_add(rho_q, neg_sat(mres_q));
			ST_P4: if (ms_done) tmp_q <= mres_q;
			ST_Q:  if (div_done) tmp_q <= num_val;
			ST_N: begin
				if ((tmp_q > 64'sd0) && (tmp_q >= vo64)) duty_q <= DUTY_MAX;
			end
			ST_U: begin
				if (div_done) duty_q <= (dq_q > 64'(DUTY_MAX)) ? DUTY_MAX : dq_q[15:0];
			end
			default: ;
		endcase
	end

	// A new sample is taken only when the sequencer is idle; the result
	// holds in its registers until the sink takes the transfer.
	assign sample.ready                = (st_q == ST_IDLE);
	assign result.valid                = (st_q == ST_OUT);
	assign result.duty                 = duty_q;
	assign result.setpoint_echo        = vs_q;
	assign result.stored_energy        = e_q;
	assign result.reference_energy     = eref_q;
	assign result.filtered_current_out = filt_q;
	assign result.fault                = fault_q;

endmodule

// ----- rtl/core/bedc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the boost energy duty controller, attached to the top
// level by the bind statement below. Uses bedc_pkg.
module bedc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] duty,
	input logic [47:0] reference_energy,
	input logic        fault
);
	import bedc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(reference_energy))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("sample taken while a result is pending");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after a sample transfer");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty <= DUTY_MAX)
		else $error("duty above clamp");

	a_fault_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> duty == 16'd0 && reference_energy == 48'd0)
		else $error("fault result carries duty or reference energy");

endmodule

bind boost_energy_duty_controller_core bedc_checker u_bedc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (sample.valid),
	.in_ready         (sample.ready),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.duty             (result.duty),
	.reference_energy (result.reference_energy),
	.fault            (result.fault)
);
